[hw/rtl/motg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor overcurrent trip guard package
// Shared constants, register indexes, mode codes and the structs passed
// between the configuration block, the evaluation core and the top level.
// ----------------------------------------------------------------------------
package motg_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int ADC_BITS_DEF   = 12;

  localparam int SAMPLE_W = 12;
  localparam int WLEN_W   = 7;
  localparam int CODE_W   = 12;
  localparam int DEV_W    = 18;
  localparam int MODE_W   = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIP_LIMIT    = 2'd2;

  localparam logic [WLEN_W-1:0] WLEN_RESET   = 7'd50;
  localparam logic [CODE_W-1:0] OFFSET_RESET = 12'd1951;
  localparam logic [CODE_W-1:0] LIMIT_RESET  = 12'd45;

  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ESTOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OVER  = 2'd2;

  typedef struct packed {
    logic [WLEN_W-1:0] window_length;
    logic [CODE_W-1:0] zero_offset_code;
    logic [CODE_W-1:0] trip_limit_code;
  } cfg_t;

  typedef struct packed {
    logic              motor_enable;
    logic [MODE_W-1:0] mode;
    logic              run_lamp;
    logic              stop_lamp;
    logic              led_low_current;
    logic              led_high_current;
    logic              window_done;
    logic [DEV_W-1:0]  window_deviation;
    logic [DEV_W-1:0]  trip_deviation;
  } res_t;

endpackage

[hw/rtl/motg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor overcurrent trip guard configuration registers
// Holds the window length, zero offset and trip limit; writes to an unknown
// index are dropped.
// ----------------------------------------------------------------------------
module motg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [motg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [motg_pkg::CFG_DATA_W-1:0] cfg_data,
  output motg_pkg::cfg_t                 cfg
);
  import motg_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length    <= WLEN_RESET;
      cfg.zero_offset_code <= OFFSET_RESET;
      cfg.trip_limit_code  <= LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: cfg.window_length    <= cfg_data[WLEN_W-1:0];
        CFG_ZERO_OFFSET:   cfg.zero_offset_code <= cfg_data[CODE_W-1:0];
        CFG_TRIP_LIMIT:    cfg.trip_limit_code  <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/motg_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor overcurrent trip guard evaluation core
// Holds the mode, button history, window accumulator and latched trip value,
// and forms the result of one item in a single combinational pass.
// ----------------------------------------------------------------------------
module motg_core #(
  parameter int MAX_WINDOW = motg_pkg::MAX_WINDOW_DEF,
  parameter int ADC_BITS   = motg_pkg::ADC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [motg_pkg::SAMPLE_W-1:0] adc_sample,
  input  logic                         button_level,
  input  motg_pkg::cfg_t               cfg,
  output motg_pkg::res_t               res
);
  import motg_pkg::*;

  localparam int SMP_W  = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = $clog2(MAX_WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int PROD_W = CNT_W + CODE_W;
  localparam int CALC_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  logic [MODE_W-1:0] run_mode, run_mode_next;
  logic              previous_button;
  logic [SUM_W-1:0]  sample_sum, sample_sum_next;
  logic [CNT_W-1:0]  sample_count, sample_count_next;
  logic [DEV_W-1:0]  latched_trip_deviation, latched_trip_deviation_next;

  logic [8:0]        wlen_ext;
  logic [CNT_W-1:0]  win;
  logic              fall;
  logic [MODE_W-1:0] mode_a;
  logic [SUM_W-1:0]  sum_a;
  logic [CNT_W-1:0]  cnt_a;
  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  cnt_acc;
  logic [PROD_W-1:0] base;
  logic [PROD_W-1:0] thresh;
  logic [CALC_W-1:0] sum_ext, base_ext, thresh_ext, deviation;
  logic              done;

  always_comb begin
    wlen_ext = {2'b00, cfg.window_length};
    if (wlen_ext == 9'd0) begin
      win = CNT_W'(1);
    end else if (wlen_ext > 9'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = wlen_ext[CNT_W-1:0];
    end
  end

  assign base       = PROD_W'(win) * PROD_W'(cfg.zero_offset_code);
  assign thresh     = PROD_W'(win) * PROD_W'(cfg.trip_limit_code);
  assign fall       = !button_level && previous_button;
  assign sum_acc    = sum_a + SUM_W'(adc_sample[SMP_W-1:0]);
  assign cnt_acc    = cnt_a + CNT_W'(1);
  assign sum_ext    = CALC_W'(sum_acc);
  assign base_ext   = CALC_W'(base);
  assign thresh_ext = CALC_W'(thresh);
  assign deviation  = (sum_ext >= base_ext) ? sum_ext - base_ext : base_ext - sum_ext;

  always_comb begin
    mode_a                      = run_mode;
    sum_a                       = sample_sum;
    cnt_a                       = sample_count;
    latched_trip_deviation_next = latched_trip_deviation;
    if (fall) begin
      sum_a = '0;
      cnt_a = '0;
      if (run_mode != MODE_RUN) begin
        mode_a                      = MODE_RUN;
        latched_trip_deviation_next = '0;
      end else begin
        mode_a = MODE_ESTOP;
      end
    end
    run_mode_next     = mode_a;
    sample_sum_next   = sum_a;
    sample_count_next = cnt_a;
    done              = 1'b0;
    if (mode_a == MODE_RUN) begin
      sample_sum_next   = sum_acc;
      sample_count_next = cnt_acc;
      if (cnt_acc >= win) begin
        done              = 1'b1;
        sample_sum_next   = '0;
        sample_count_next = '0;
        if (deviation >= thresh_ext) begin
          run_mode_next               = MODE_OVER;
          latched_trip_deviation_next = deviation[DEV_W-1:0];
        end
      end
    end
  end

  always_comb begin
    res.motor_enable     = (run_mode_next == MODE_RUN);
    res.mode             = run_mode_next;
    res.run_lamp         = (run_mode_next == MODE_RUN);
    res.stop_lamp        = (run_mode_next != MODE_RUN);
    res.led_low_current  = (run_mode_next == MODE_RUN);
    res.led_high_current = (run_mode_next == MODE_OVER);
    res.window_done      = done;
    res.window_deviation = done ? deviation[DEV_W-1:0] : '0;
    res.trip_deviation   = latched_trip_deviation_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode               <= MODE_RUN;
      previous_button        <= 1'b1;
      sample_sum             <= '0;
      sample_count           <= '0;
      latched_trip_deviation <= '0;
    end else if (step) begin
      run_mode               <= run_mode_next;
      previous_button        <= button_level;
      sample_sum             <= sample_sum_next;
      sample_count           <= sample_count_next;
      latched_trip_deviation <= latched_trip_deviation_next;
    end
  end

`ifndef SYNTHESIS
  a_trip_held_only_in_over: assert property (@(posedge clk) disable iff (rst)
    latched_trip_deviation != '0 |-> run_mode == MODE_OVER)
    else $error("Latched trip value is set outside overcurrent lockout.");
  a_count_below_max: assert property (@(posedge clk) disable iff (rst)
    sample_count < CNT_W'(MAX_WINDOW))
    else $error("Window count reached the maximum window without completing.");
  a_idle_window_in_lockout: assert property (@(posedge clk) disable iff (rst)
    run_mode != MODE_RUN |-> sample_count == '0 && sample_sum == '0)
    else $error("Partial window kept during a lockout.");
`endif

endmodule

[hw/rtl/motor_overcurrent_trip_guard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor overcurrent trip guard
// Tracks run, e-stop and overcurrent lockout modes from the button level and
// windowed ADC current samples, and drives the relay and indicator outputs.
//
//   Channel   Signals                                      Direction
//   sample    sample_valid, sample_ready, adc_sample,      in
//             button_level
//   result    result_valid, result_ready, motor_enable ... out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data    in
//
// One item passes from the input register through the evaluation core into
// the result register; an item is accepted every cycle while results are
// taken, and result_valid rises when the item is written into the result
// register. The evaluation core is combinational. Reset restores the
// register defaults and running mode. A stalled result holds the result
// register; the input register still takes one further item, then
// sample_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module motor_overcurrent_trip_guard #(
  parameter int MAX_WINDOW = motg_pkg::MAX_WINDOW_DEF,
  parameter int ADC_BITS   = motg_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic [motg_pkg::SAMPLE_W-1:0]   adc_sample,
  input  logic                           button_level,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           motor_enable,
  output logic [motg_pkg::MODE_W-1:0]     mode,
  output logic                           run_lamp,
  output logic                           stop_lamp,
  output logic                           led_low_current,
  output logic                           led_high_current,
  output logic                           window_done,
  output logic [motg_pkg::DEV_W-1:0]      window_deviation,
  output logic [motg_pkg::DEV_W-1:0]      trip_deviation,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [motg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [motg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import motg_pkg::*;

  cfg_t                cfg;
  res_t                res;
  res_t                res_reg;
  logic                hold_valid;
  logic [SAMPLE_W-1:0] hold_sample;
  logic                hold_button;
  logic                advance;

  assign advance      = hold_valid && (!result_valid || result_ready);
  assign sample_ready = !hold_valid || advance;

  motg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  motg_core #(
    .MAX_WINDOW (MAX_WINDOW),
    .ADC_BITS   (ADC_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .adc_sample   (hold_sample),
    .button_level (hold_button),
    .cfg          (cfg),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_ready) begin
      hold_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      hold_sample <= adc_sample;
      hold_button <= button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res;
    end
  end

  assign motor_enable     = res_reg.motor_enable;
  assign mode             = res_reg.mode;
  assign run_lamp         = res_reg.run_lamp;
  assign stop_lamp        = res_reg.stop_lamp;
  assign led_low_current  = res_reg.led_low_current;
  assign led_high_current = res_reg.led_high_current;
  assign window_done      = res_reg.window_done;
  assign window_deviation = res_reg.window_deviation;
  assign trip_deviation   = res_reg.trip_deviation;

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> hold_valid && result_valid)
    else $error("Input stalled while the pipeline has room.");
  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("An item left the input register but no result is shown.");
  a_hold_kept_on_stall: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_sample) && $stable(hold_button))
    else $error("A held item was lost or changed while stalled.");
`endif

endmodule
